/* sv/dtar_pkg.sv */
// ----------------------------------------------------------------------------
// dtar_pkg
// Shared types and constants for the distance readout formatter.
// ----------------------------------------------------------------------------
package dtar_pkg;

  // Field and datapath widths.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned SCALE_SHIFT = 10;
  // Largest distance is 4095*4095/1024 + 4095 = 20470, which fits 15 bits.
  localparam int unsigned DIST_W     = 15;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;

  // Divide by ten as multiply by reciprocal; exact for all 16-bit operands.
  localparam int unsigned DIV10_MUL_W = 16;
  localparam int unsigned DIV10_PROD_W = DIST_W + DIV10_MUL_W;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // Configuration register indexes.
  typedef enum logic {
    REG_GAIN   = 1'b0,
    REG_OFFSET = 1'b1
  } cfg_reg_t;

  // Register reset values.
  localparam logic [CFG_W-1:0] GAIN_RESET   = 12'd740;
  localparam logic [CFG_W-1:0] OFFSET_RESET = 12'd3;

  // Readout characters.
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;

endpackage

/* sv/adc_distance_to_ascii_readout.sv */
// ----------------------------------------------------------------------------
// adc_distance_to_ascii_readout
// Scales a 12-bit converter sample to a distance and sends it as ASCII text.
// ----------------------------------------------------------------------------
// Each accepted sample becomes distance = gain*sample/1024 + offset, in units
// of 10^-FRACTION_DIGITS cm, and leaves as the text "d.ddd cm", one character
// per output beat, most significant first, tlast on the final 'm'. A distance
// beyond the display range shows '*' in every digit place. One sample yields
// FRACTION_DIGITS+5 characters (8 by default); the character serializer takes
// the next sample only as the last character of the one before enters the
// output register. The first character of an accepted sample passes through
// the register stages in order: two scaling stages, one stage per decimal
// digit, the readout buffer and the output register. Samples may be offered
// at any time; the pipeline holds them while the serializer is busy. The
// configuration port is always ready; gain and offset should be written only
// while idle.
// ----------------------------------------------------------------------------
module adc_distance_to_ascii_readout
  import dtar_pkg::*;
#(
  parameter int unsigned FRACTION_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_sample, [15:12] zero fill
  // Character output.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] text_char
  output logic        out_tlast,  // last_char
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,  // 0 gain, 1 offset
  input  logic [11:0] cfg_data
);

  logic [CFG_W-1:0] gain_r;
  logic [CFG_W-1:0] offset_r;

  logic                                  adv;
  logic                                  sc_v;
  logic [DIST_W-1:0]                     sc_dist;
  logic                                  sc_over;
  logic                                  dg_v;
  logic [FRACTION_DIGITS:0][DIGIT_W-1:0] dg_digits;
  logic                                  dg_over;
  logic                                  ser_ready;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN:   gain_r   <= cfg_data;
        REG_OFFSET: offset_r <= cfg_data;
        default:    gain_r   <= gain_r;
      endcase
    end
  end

  // The whole pipeline moves when its last stage is empty or drains.
  assign adv       = !dg_v || ser_ready;
  assign in_tready = adv;

  dtar_scale #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .v_in     (in_tvalid),
    .sample_in(in_tdata[SAMPLE_W-1:0]),
    .gain     (gain_r),
    .offset   (offset_r),
    .v_out    (sc_v),
    .dist_out (sc_dist),
    .over_out (sc_over)
  );

  dtar_digits #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .v_in      (sc_v),
    .dist_in   (sc_dist),
    .over_in   (sc_over),
    .v_out     (dg_v),
    .digits_out(dg_digits),
    .over_out  (dg_over)
  );

  dtar_serial #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .v_in     (dg_v),
    .digits_in(dg_digits),
    .over_in  (dg_over),
    .ready    (ser_ready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_char (out_tdata),
    .out_last (out_tlast)
  );

endmodule

/* sv/dtar_scale.sv */
// ----------------------------------------------------------------------------
// dtar_scale
// Two-stage linear scaling: gain times sample, then divide by 1024, add the
// offset and flag a distance beyond the display range.
// ----------------------------------------------------------------------------
module dtar_scale
  import dtar_pkg::*;
#(
  parameter int unsigned FRACTION_DIGITS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                v_in,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic [CFG_W-1:0]    gain,
  input  logic [CFG_W-1:0]    offset,
  output logic                v_out,
  output logic [DIST_W-1:0]   dist_out,
  output logic                over_out
);

  localparam int unsigned DIGITS = FRACTION_DIGITS + 1;
  localparam longint unsigned LIMIT = (64'd10 ** DIGITS) - 64'd1;

  logic              v_a_r;
  logic [PROD_W-1:0] prod_r;
  logic              v_b_r;
  logic [DIST_W-1:0] dist_r;
  logic              over_r;
  logic [DIST_W-1:0] dist_nxt;

  // Stage A valid and stage B valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
    end else if (en) begin
      v_a_r <= v_in;
      v_b_r <= v_a_r;
    end
  end

  // Stage B sum: the product is truncated by dropping its low ten bits.
  always_comb begin
    dist_nxt = DIST_W'(prod_r[PROD_W-1:SCALE_SHIFT]) + DIST_W'(offset);
  end

  // Payload of both stages.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(gain) * PROD_W'(sample_in);
      dist_r <= dist_nxt;
      over_r <= 64'(dist_nxt) > LIMIT;
    end
  end

  assign v_out    = v_b_r;
  assign dist_out = dist_r;
  assign over_out = over_r;

endmodule

/* sv/dtar_digits.sv */
// ----------------------------------------------------------------------------
// dtar_digits
// Decimal digit extraction, one digit per pipeline stage, least significant
// digit first.
// ----------------------------------------------------------------------------
module dtar_digits
  import dtar_pkg::*;
#(
  parameter int unsigned FRACTION_DIGITS = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               v_in,
  input  logic [DIST_W-1:0]                  dist_in,
  input  logic                               over_in,
  output logic                               v_out,
  output logic [FRACTION_DIGITS:0][DIGIT_W-1:0] digits_out,
  output logic                               over_out
);

  localparam int unsigned DIGITS = FRACTION_DIGITS + 1;

  logic [DIGITS-1:0]                           v_r;
  logic [DIGITS-1:0]                           over_r;
  logic [DIGITS-1:0][DIST_W-1:0]               rest_r;
  logic [DIGITS-1:0][DIGITS-1:0][DIGIT_W-1:0]  dig_r;

  for (genvar i = 0; i < DIGITS; i++) begin : g_stage
    logic                              src_v;
    logic                              src_over;
    logic [DIST_W-1:0]                 src_rest;
    logic [DIGITS-1:0][DIGIT_W-1:0]    src_dig;
    logic [DIV10_PROD_W-1:0]           q_prod;
    logic [DIST_W-1:0]                 quot;
    logic [DIST_W-1:0]                 rem_full;
    logic [DIGITS-1:0][DIGIT_W-1:0]    dig_nxt;

    // Source of this stage: the pipeline input or the stage before.
    if (i == 0) begin : g_first
      assign src_v    = v_in;
      assign src_over = over_in;
      assign src_rest = dist_in;
      assign src_dig  = '0;
    end else begin : g_next
      assign src_v    = v_r[i-1];
      assign src_over = over_r[i-1];
      assign src_rest = rest_r[i-1];
      assign src_dig  = dig_r[i-1];
    end

    // Quotient and remainder by ten; the remainder joins the digit vector.
    always_comb begin
      q_prod     = DIV10_PROD_W'(src_rest) * DIV10_PROD_W'(DIV10_MUL);
      quot       = DIST_W'(q_prod >> DIV10_SHIFT);
      rem_full   = src_rest - ((quot << 3) + (quot << 1));
      dig_nxt    = src_dig;
      dig_nxt[i] = DIGIT_W'(rem_full);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        over_r[i] <= src_over;
        rest_r[i] <= quot;
        dig_r[i]  <= dig_nxt;
      end
    end
  end

  assign v_out      = v_r[DIGITS-1];
  assign over_out   = over_r[DIGITS-1];
  assign digits_out = dig_r[DIGITS-1];

endmodule

/* sv/dtar_serial.sv */
// ----------------------------------------------------------------------------
// dtar_serial
// Holds one formatted readout and sends its characters one beat at a time
// through a registered output stage.
// ----------------------------------------------------------------------------
module dtar_serial
  import dtar_pkg::*;
#(
  parameter int unsigned FRACTION_DIGITS = 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  v_in,
  input  logic [FRACTION_DIGITS:0][DIGIT_W-1:0] digits_in,
  input  logic                                  over_in,
  output logic                                  ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [CHAR_W-1:0]                     out_char,
  output logic                                  out_last
);

  localparam int unsigned DIGITS = FRACTION_DIGITS + 1;
  localparam int unsigned LEN    = FRACTION_DIGITS + 5;
  localparam int unsigned CNT_W  = $clog2(LEN);
  localparam int unsigned DSEL_W = $clog2(DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(LEN - 1);
  localparam logic [CNT_W-1:0] CNT_POINT = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FRAC  = CNT_W'(FRACTION_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_SPACE = CNT_W'(FRACTION_DIGITS + 2);
  localparam logic [CNT_W-1:0] CNT_C     = CNT_W'(FRACTION_DIGITS + 3);

  logic                             busy_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [DIGITS-1:0][DIGIT_W-1:0]   dig_r;
  logic                             over_r;
  logic                             oval_r;
  logic [CHAR_W-1:0]                ochar_r;
  logic                             olast_r;

  logic                             out_adv;
  logic                             emit;
  logic                             take;
  logic [DSEL_W-1:0]                dsel;
  logic [CHAR_W-1:0]                digit_char;
  logic [CHAR_W-1:0]                char_nxt;

  // Output register may load when empty or being drained this cycle.
  assign out_adv = !oval_r || out_ready;
  assign emit    = busy_r && out_adv;
  assign ready   = !busy_r || (emit && (cnt_r == CNT_LAST));
  assign take    = v_in && ready;

  // Character at the current position.
  always_comb begin
    dsel       = DSEL_W'(CNT_FRAC - cnt_r);
    digit_char = over_r ? CH_STAR : (CH_ZERO + CHAR_W'(dig_r[dsel]));
    if (cnt_r == '0) begin
      char_nxt = over_r ? CH_STAR : (CH_ZERO + CHAR_W'(dig_r[DIGITS-1]));
    end else if (cnt_r == CNT_POINT) begin
      char_nxt = CH_POINT;
    end else if (cnt_r <= CNT_FRAC) begin
      char_nxt = digit_char;
    end else if (cnt_r == CNT_SPACE) begin
      char_nxt = CH_SPACE;
    end else if (cnt_r == CNT_C) begin
      char_nxt = CH_C;
    end else begin
      char_nxt = CH_M;
    end
  end

  // Readout buffer control and position counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (emit) begin
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Readout payload.
  always_ff @(posedge clk) begin
    if (take) begin
      dig_r  <= digits_in;
      over_r <= over_in;
    end
  end

  // Registered output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (out_adv) begin
      oval_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ochar_r <= char_nxt;
      olast_r <= (cnt_r == CNT_LAST);
    end
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

`ifndef SYNTH
  // An idle buffer always restarts at the first character.
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("dtar_serial: counter not at start while idle");

  // The last beat of a readout is always the letter m.
  a_last_m: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && olast_r |-> ochar_r == CH_M)
    else $error("dtar_serial: last beat is not the unit letter");

  // A new readout is only taken as the previous one's last character is emitted.
  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    take && busy_r |-> cnt_r == CNT_LAST && out_adv)
    else $error("dtar_serial: readout overwritten before completion");

  // The position counter stays inside the readout.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("dtar_serial: position beyond readout length");
`endif

endmodule
